// ===== design/pis_pkg.sv =====
// Shared types and constants for the Poisson inversion sampler.
// Holds the state encodings, register indexes and datapath widths.
// No dependencies.
package pis_pkg;

    // Datapath widths
    localparam int PROB_W  = 32;
    localparam int RATE_W  = 16;
    localparam int TOL_W   = 16;
    localparam int K_W     = 6;
    localparam int CFG_W   = 32;
    localparam int PROD_W  = PROB_W + RATE_W;
    localparam int FRAC_W  = 12;
    localparam int QUOT_W  = PROD_W - FRAC_W;
    localparam int TOTAL_W = PROB_W + 1;
    localparam int CNT_W   = 6;

    // Serial step counts
    localparam int MUL_STEPS = RATE_W;
    localparam int DIV_STEPS = QUOT_W;

    // Search limit and the smallest raw rate that is sampled
    localparam logic [K_W-1:0]    MAX_COUNT    = 6'd63;
    localparam logic [RATE_W-1:0] RATE_MIN_RAW = 16'd5;

    // Configuration register reset values
    localparam logic [RATE_W-1:0] RATE_RESET = 16'd0;
    localparam logic [PROB_W-1:0] ENR_RESET  = 32'hFFFF_FFFF;
    localparam logic [TOL_W-1:0]  TOL_RESET  = 16'd4295;

    // Configuration register indexes
    typedef enum logic [1:0] {
        CFG_RATE         = 2'd0,
        CFG_EXP_NEG_RATE = 2'd1,
        CFG_TOLERANCE    = 2'd2
    } cfg_idx_t;

    // Top-level sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_CALC,
        ST_FINISH
    } pis_state_t;

    // Serial multiply/divide unit states
    typedef enum logic [1:0] {
        MD_IDLE,
        MD_MUL,
        MD_DIV
    } md_state_t;

    // Status returned by the serial unit
    typedef struct packed {
        logic busy;
        logic done;
    } md_status_t;

endpackage

// ===== design/pis_serial_muldiv.sv =====
// Bit-serial unit that computes p_next = sat32(floor(floor(p * rate / 4096) / k)).
// A shift-add multiplier takes one rate bit per cycle, then a restoring divider
// produces one quotient bit per cycle. Depends on pis_pkg.
module pis_serial_muldiv
    import pis_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [PROB_W-1:0] p,
    input  logic [RATE_W-1:0] rate,
    input  logic [K_W-1:0]    k,
    output md_status_t        status,
    output logic [PROB_W-1:0] p_next
);

    md_state_t           st_reg, st_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic [PROD_W-1:0]   prod_reg, prod_next;
    logic [QUOT_W-1:0]   dq_reg, dq_next;
    logic [K_W-1:0]      rem_reg, rem_next;
    logic [K_W-1:0]      div_reg, div_next;
    logic                done_reg, done_next;
    logic [PROB_W-1:0]   res_reg, res_next;

    logic [PROB_W:0]     mul_sum;
    logic [K_W:0]        trial;
    logic                trial_ge;

    // One shift-add step of the multiplier
    assign mul_sum = {1'b0, prod_reg[PROD_W-1:RATE_W]}
                   + (prod_reg[0] ? {1'b0, p} : {(PROB_W+1){1'b0}});

    // One restoring divide step
    assign trial    = {rem_reg, dq_reg[QUOT_W-1]};
    assign trial_ge = (trial >= {1'b0, div_reg});

    // State register and datapath registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg   <= MD_IDLE;
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            st_reg   <= st_next;
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        dq_reg   <= dq_next;
        rem_reg  <= rem_next;
        div_reg  <= div_next;
        res_reg  <= res_next;
    end

    // Next state and datapath control
    always_comb
    begin
        st_next   = st_reg;
        cnt_next  = cnt_reg;
        prod_next = prod_reg;
        dq_next   = dq_reg;
        rem_next  = rem_reg;
        div_next  = div_reg;
        res_next  = res_reg;
        done_next = 1'b0;
        case (st_reg)
            MD_IDLE:
            begin
                if (start)
                begin
                    prod_next = {{PROB_W{1'b0}}, rate};
                    div_next  = k;
                    cnt_next  = '0;
                    st_next   = MD_MUL;
                end
            end
            MD_MUL:
            begin
                prod_next = {mul_sum, prod_reg[RATE_W-1:1]};
                cnt_next  = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(MUL_STEPS - 1))
                begin
                    // The low fraction bits of the product drop out here.
                    dq_next  = prod_next[PROD_W-1:FRAC_W];
                    rem_next = '0;
                    cnt_next = '0;
                    st_next  = MD_DIV;
                end
            end
            MD_DIV:
            begin
                rem_next = trial_ge ? K_W'(trial - {1'b0, div_reg}) : trial[K_W-1:0];
                dq_next  = {dq_reg[QUOT_W-2:0], trial_ge};
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(DIV_STEPS - 1))
                begin
                    // Saturate the quotient to a 32-bit fraction.
                    res_next  = (|dq_next[QUOT_W-1:PROB_W]) ? {PROB_W{1'b1}}
                                                             : dq_next[PROB_W-1:0];
                    done_next = 1'b1;
                    st_next   = MD_IDLE;
                end
            end
            default:
            begin
                st_next = MD_IDLE;
            end
        endcase
    end

    assign status.busy = (st_reg != MD_IDLE);
    assign status.done = done_reg;
    assign p_next      = res_reg;

    // Checks
    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> (st_reg == MD_IDLE))
        else $error("serial unit started while busy");
    a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (st_reg == MD_DIV) |-> (div_reg != '0))
        else $error("divide by zero count");
    a_done_after_div: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(st_reg == MD_DIV))
        else $error("done without a divide pass");

endmodule

// ===== design/poisson_inversion_sampler_core.sv =====
// Poisson inversion sampler: maps a uniform 32-bit fraction to a Poisson count.
// Top level with the search sequencer; uses pis_pkg and pis_serial_muldiv.
//
// Usage:
//   Requests arrive on in_valid/in_ready with a 32-bit uniform value. Each
//   request yields exactly one result on out_valid/out_ready carrying the
//   sampled count and a saturated flag (set when the search hit the limit of
//   63). Configuration is written through cfg_we/cfg_index/cfg_data while the
//   block is idle: index 0 rate (UQ4.12), 1 e^-rate (UQ0.32), 2 tolerance.
//   Flow: one request is searched at a time; the next is accepted only after
//   the result is handed to the output register. Each search step is a
//   compare in ST_CHECK, a shift-add multiply by the rate, a restoring
//   divide by k and the hand-back of the new p. A rate below 5/4096 or a
//   threshold already reached skips the search and goes to ST_FINISH.
//   An output register holds a finished result, so the next request is taken
//   and searched while the receiver stalls; the search then waits until the
//   output register is free.
//   Reset (rst_n, asynchronous, active low) clears the sequencer, drops
//   out_valid and restores the register defaults.
module poisson_inversion_sampler_core
    import pis_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [1:0]        cfg_index,
    input  logic [CFG_W-1:0]  cfg_data,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [PROB_W-1:0] uniform,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [K_W-1:0]    count,
    output logic              saturated
);

    pis_state_t           st_reg, st_next;
    logic [RATE_W-1:0]    rate_reg;
    logic [PROB_W-1:0]    enr_reg;
    logic [TOL_W-1:0]     tol_reg;
    logic [PROB_W-1:0]    thr_reg, thr_next;
    logic [PROB_W-1:0]    p_reg, p_next;
    logic [TOTAL_W-1:0]   total_reg, total_next;
    logic [K_W-1:0]       k_reg, k_next;
    logic                 sat_reg, sat_next;
    logic                 out_valid_reg, out_valid_next;
    logic [K_W-1:0]       count_reg, count_next;
    logic                 saturated_reg, saturated_next;
    logic                 md_start;
    md_status_t           md_stat;
    logic [PROB_W-1:0]    md_p;

    // Serial multiply and divide for one search step; it divides by the new k.
    pis_serial_muldiv u_muldiv (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (md_start),
        .p      (p_reg),
        .rate   (rate_reg),
        .k      (k_next),
        .status (md_stat),
        .p_next (md_p)
    );

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rate_reg <= RATE_RESET;
            enr_reg  <= ENR_RESET;
            tol_reg  <= TOL_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_RATE:         rate_reg <= cfg_data[RATE_W-1:0];
                CFG_EXP_NEG_RATE: enr_reg  <= cfg_data[PROB_W-1:0];
                CFG_TOLERANCE:    tol_reg  <= cfg_data[TOL_W-1:0];
                default:          ;
            endcase
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg        <= ST_IDLE;
            out_valid_reg <= 1'b0;
            k_reg         <= '0;
            sat_reg       <= 1'b0;
        end
        else
        begin
            st_reg        <= st_next;
            out_valid_reg <= out_valid_next;
            k_reg         <= k_next;
            sat_reg       <= sat_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        thr_reg       <= thr_next;
        p_reg         <= p_next;
        total_reg     <= total_next;
        count_reg     <= count_next;
        saturated_reg <= saturated_next;
    end

    // Search sequencer
    always_comb
    begin
        st_next        = st_reg;
        thr_next       = thr_reg;
        p_next         = p_reg;
        total_next     = total_reg;
        k_next         = k_reg;
        sat_next       = sat_reg;
        count_next     = count_reg;
        saturated_next = saturated_reg;
        out_valid_next = out_valid_reg && !out_ready;
        md_start       = 1'b0;
        in_ready       = 1'b0;
        case (st_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    // Threshold is the uniform value less the slack, floored at zero.
                    thr_next   = (uniform > {{(PROB_W-TOL_W){1'b0}}, tol_reg})
                               ? uniform - {{(PROB_W-TOL_W){1'b0}}, tol_reg}
                               : '0;
                    p_next     = enr_reg;
                    total_next = {1'b0, enr_reg};
                    k_next     = '0;
                    sat_next   = 1'b0;
                    st_next    = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (rate_reg < RATE_MIN_RAW)
                begin
                    k_next  = '0;
                    st_next = ST_FINISH;
                end
                else if (total_reg < {1'b0, thr_reg})
                begin
                    if (k_reg >= MAX_COUNT)
                    begin
                        sat_next = 1'b1;
                        st_next  = ST_FINISH;
                    end
                    else
                    begin
                        k_next   = k_reg + 1'b1;
                        md_start = 1'b1;
                        st_next  = ST_CALC;
                    end
                end
                else
                begin
                    st_next = ST_FINISH;
                end
            end
            ST_CALC:
            begin
                // Total stays below 2^32 here, so the sum fits in 33 bits.
                if (md_stat.done)
                begin
                    p_next     = md_p;
                    total_next = total_reg + {1'b0, md_p};
                    st_next    = ST_CHECK;
                end
            end
            ST_FINISH:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    count_next     = k_reg;
                    saturated_next = sat_reg;
                    out_valid_next = 1'b1;
                    st_next        = ST_IDLE;
                end
            end
            default:
            begin
                st_next = ST_IDLE;
            end
        endcase
    end

    assign out_valid = out_valid_reg;
    assign count     = count_reg;
    assign saturated = saturated_reg;

    // Checks
    a_sat_at_limit: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && saturated_reg) |-> (count_reg == MAX_COUNT))
        else $error("saturated result below the count limit");
    a_k_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        (k_reg <= MAX_COUNT))
        else $error("count ran past the limit");
    a_done_in_calc: assert property (@(posedge clk) disable iff (!rst_n)
        md_stat.done |-> (st_reg == ST_CALC))
        else $error("serial result arrived outside a search step");
    a_busy_in_calc: assert property (@(posedge clk) disable iff (!rst_n)
        md_stat.busy |-> (st_reg == ST_CALC))
        else $error("serial unit busy outside a search step");

endmodule

// ===== verif/pis_sample_checker.sv =====
// Scoreboard for the Poisson inversion sampler: mirrors the register file,
// predicts each count and saturated flag, and compares accepted results in order.
// Depends on pis_pkg for widths, limits, reset values and register indexes.
module pis_sample_checker
    import pis_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [1:0]        cfg_index,
    input  logic [CFG_W-1:0]  cfg_data,
    input  logic              in_valid,
    input  logic              in_ready,
    input  logic [PROB_W-1:0] uniform,
    input  logic              out_valid,
    input  logic              out_ready,
    input  logic [K_W-1:0]    count,
    input  logic              saturated,
    output int                errors,
    output int                pending,
    output int                requests,
    output int                saturations
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [63:0] P_LIMIT     = 64'hFFFF_FFFF;
    localparam int          REPORT_MAX  = 10;

    typedef struct packed {
        logic [K_W-1:0] count;
        logic           saturated;
    } sample_t;

    // Local copy of the register file
    logic [RATE_W-1:0] rate_q;
    logic [PROB_W-1:0] enr_q;
    logic [TOL_W-1:0]  tol_q;

    sample_t expected_samples[$];
    int      mismatch_cnt;
    int      request_cnt;
    int      result_cnt;
    int      sat_cnt;

    // Inverse-transform search in 64-bit fixed point, truncating each step.
    function automatic sample_t poisson_count_of(
        input logic [PROB_W-1:0] u,
        input logic [RATE_W-1:0] lam,
        input logic [PROB_W-1:0] enr,
        input logic [TOL_W-1:0]  tol
    );
        sample_t     s;
        logic [63:0] thr;
        logic [63:0] p;
        logic [63:0] total;
        int          k;
        s = '0;
        k = 0;
        if (lam < RATE_MIN_RAW) begin
            return s;
        end
        thr   = (64'(u) > 64'(tol)) ? (64'(u) - 64'(tol)) : 64'd0;
        p     = 64'(enr);
        total = p;
        while (total < thr) begin
            if (k >= int'(MAX_COUNT)) begin
                s.saturated = 1'b1;
                break;
            end
            k++;
            p = (p * 64'(lam)) / (64'(k) << FRAC_W);
            if (p > P_LIMIT) begin
                p = P_LIMIT;
            end
            total += p;
        end
        s.count = K_W'(k);
        return s;
    endfunction

    // Track register writes, queue predictions and check results in order.
    always @(posedge clk or negedge rst_n)
    begin
        sample_t want;
        if (!rst_n) begin
            rate_q       = RATE_RESET;
            enr_q        = ENR_RESET;
            tol_q        = TOL_RESET;
            mismatch_cnt = 0;
            request_cnt  = 0;
            result_cnt   = 0;
            sat_cnt      = 0;
            expected_samples.delete();
        end else begin
            if (out_valid && out_ready) begin
                result_cnt++;
                if (expected_samples.size() == 0) begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= REPORT_MAX) begin
                        $display("[%0t] result with no request waiting: count %0d saturated %0b",
                                 $realtime, count, saturated);
                    end
                end else begin
                    want = expected_samples.pop_front();
                    if (want.saturated) begin
                        sat_cnt++;
                    end
                    if (count !== want.count || saturated !== want.saturated) begin
                        mismatch_cnt++;
                        if (mismatch_cnt <= REPORT_MAX) begin
                            $display(
                                "[%0t] result %0d: count exp %0d got %0d, sat exp %0b got %0b",
                                $realtime, result_cnt, want.count, count,
                                want.saturated, saturated);
                        end
                    end
                end
            end
            if (in_valid && in_ready) begin
                request_cnt++;
                expected_samples.insert(expected_samples.size(),
                                        poisson_count_of(uniform, rate_q, enr_q, tol_q));
            end
            if (cfg_we) begin
                case (cfg_idx_t'(cfg_index))
                    CFG_RATE:         rate_q = cfg_data[RATE_W-1:0];
                    CFG_EXP_NEG_RATE: enr_q  = cfg_data[PROB_W-1:0];
                    CFG_TOLERANCE:    tol_q  = cfg_data[TOL_W-1:0];
                    default:          ;
                endcase
            end
        end
        errors      <= mismatch_cnt;
        pending     <= expected_samples.size();
        requests    <= request_cnt;
        saturations <= sat_cnt;
    end

endmodule

// ===== verif/poisson_inversion_sampler_core_tb.sv =====
// Testbench top for poisson_inversion_sampler_core: clock, reset, register
// settings, request and result traffic with random stalls, and the verdict.
// Depends on pis_pkg, the block itself and pis_sample_checker.
module poisson_inversion_sampler_core_tb;
    import pis_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT  = 40000;
    localparam int RANDOM_PHASES   = 8;
    localparam int PHASE_ITEMS     = 50;
    localparam int PRESSURE_AT     = 60;
    localparam int PRESSURE_CYCLES = 8000;
    localparam int DRAIN_CYCLES    = 300;

    logic              clk;
    logic              rst_n;
    logic              cfg_we;
    logic [1:0]        cfg_index;
    logic [CFG_W-1:0]  cfg_data;
    logic              in_valid;
    logic              in_ready;
    logic [PROB_W-1:0] uniform;
    logic              out_valid;
    logic              out_ready;
    logic [K_W-1:0]    count;
    logic              saturated;

    int chk_errors;
    int chk_pending;
    int chk_requests;
    int chk_saturations;
    int settings_done;
    int idle_cycles;
    bit sender_calm;

    poisson_inversion_sampler_core u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .uniform   (uniform),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .count     (count),
        .saturated (saturated)
    );

    pis_sample_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .uniform     (uniform),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .count       (count),
        .saturated   (saturated),
        .errors      (chk_errors),
        .pending     (chk_pending),
        .requests    (chk_requests),
        .saturations (chk_saturations)
    );

    // 50 MHz clock
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Mostly short gaps, now and then a long one.
    function automatic int pick_gap();
        if ($urandom_range(0, 9) < 6) begin
            return 0;
        end
        if ($urandom_range(0, 19) == 0) begin
            return $urandom_range(20, 60);
        end
        return $urandom_range(1, 4);
    endfunction

    // Software-side e^-rate as a UQ0.32 word, clamped at all ones.
    function automatic logic [PROB_W-1:0] exp_neg_of(input logic [RATE_W-1:0] r);
        real x;
        x = $exp(-(real'(r) / 4096.0)) * 4294967296.0;
        if (x >= 4294967295.0) begin
            return 32'hFFFF_FFFF;
        end
        return PROB_W'(longint'(x));
    endfunction

    // Wait until every queued request has produced its result.
    task automatic wait_idle();
        @(posedge clk);
        while (chk_pending != 0) begin
            @(posedge clk);
        end
    endtask

    // Write all three registers back to back while the block is idle.
    task automatic set_config(
        input logic [CFG_W-1:0] rate_word,
        input logic [CFG_W-1:0] enr_word,
        input logic [CFG_W-1:0] tol_word
    );
        wait_idle();
        cfg_we    <= 1'b1;
        cfg_index <= CFG_RATE;
        cfg_data  <= rate_word;
        @(posedge clk);
        cfg_index <= CFG_EXP_NEG_RATE;
        cfg_data  <= enr_word;
        @(posedge clk);
        cfg_index <= CFG_TOLERANCE;
        cfg_data  <= tol_word;
        @(posedge clk);
        cfg_we    <= 1'b0;
        @(posedge clk);
        settings_done++;
    endtask

    // Offer one request after an optional gap and hold it until accepted.
    // Ready is looked at mid-cycle, so the loop ends on the accepting edge.
    task automatic offer_uniform(input logic [PROB_W-1:0] val);
        int gap;
        bit taken;
        gap = sender_calm ? 0 : pick_gap();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        uniform  <= val;
        do begin
            @(negedge clk);
            taken = in_ready;
            @(posedge clk);
        end while (!taken);
    endtask

    // Result side: random stalls, calm stretches, and one long hold-off.
    initial
    begin : receiver
        int gap_left;
        int hold_left;
        int calm_left;
        bit held_once;
        gap_left  = 0;
        hold_left = 0;
        calm_left = 0;
        held_once = 1'b0;
        out_ready <= 1'b0;
        @(posedge rst_n);
        forever begin
            @(posedge clk);
            if (!held_once && chk_requests >= PRESSURE_AT) begin
                held_once = 1'b1;
                hold_left = PRESSURE_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_ready <= 1'b0;
            end else if (gap_left > 0) begin
                gap_left--;
                out_ready <= 1'b0;
            end else begin
                out_ready <= 1'b1;
                if (calm_left > 0) begin
                    calm_left--;
                end else if ($urandom_range(0, 199) == 0) begin
                    calm_left = $urandom_range(100, 300);
                end else if ($urandom_range(0, 2) == 0) begin
                    gap_left = pick_gap();
                end
            end
        end
    end

    // Watchdog: too long without any request or result moving.
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no traffic for %0d cycles, %0d results outstanding",
                     idle_cycles, chk_pending);
            $display("** poisson_inversion_sampler_core: FAILED **");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Stimulus and verdict
    initial
    begin : stimulus
        logic [RATE_W-1:0] lam;
        logic [PROB_W-1:0] enr;
        logic [TOL_W-1:0]  tol;
        logic [PROB_W-1:0] u;
        int                pick;
        settings_done = 0;
        idle_cycles   = 0;
        sender_calm   = 1'b0;
        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_index     = CFG_RATE;
        cfg_data      = '0;
        in_valid      = 1'b0;
        uniform       = '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: rate 0 is below the sampling floor.
        offer_uniform(32'h0000_0000);
        offer_uniform(32'hFFFF_FFFF);
        offer_uniform(32'h8000_0000);
        in_valid <= 1'b0;

        // Largest rate that still falls below the floor.
        set_config(32'd4, exp_neg_of(16'd4), 32'(TOL_RESET));
        offer_uniform(32'hFFFF_FFFF);
        in_valid <= 1'b0;

        // Smallest rate that is sampled.
        set_config(32'd5, exp_neg_of(16'd5), 32'(TOL_RESET));
        offer_uniform(32'h0000_0000);
        offer_uniform(32'h7FFF_FFFF);
        offer_uniform(32'hFFFF_FFFF);
        in_valid <= 1'b0;

        // Largest rate with zero tolerance.
        set_config(32'h0000_FFFF, exp_neg_of(16'hFFFF), 32'd0);
        offer_uniform(32'h0000_0000);
        offer_uniform(32'h0000_0001);
        offer_uniform(32'h8000_0000);
        offer_uniform(32'hFFFF_FFFF);
        in_valid <= 1'b0;

        // Zero e^-rate: tolerance equal to the uniform value, then exhausted searches.
        set_config(32'h0000_1000, 32'd0, 32'h0000_FFFF);
        offer_uniform(32'h0000_FFFF);
        offer_uniform(32'h0001_0000);
        offer_uniform(32'hFFFF_FFFF);
        in_valid <= 1'b0;

        // Inconsistent e^-rate that drives p into its ceiling.
        set_config(32'h0000_FFFF, 32'h8000_0000, 32'd0);
        offer_uniform(32'hFFFF_FFFF);
        offer_uniform(32'h1234_5678);
        in_valid <= 1'b0;

        // Random phases, each with its own register setting.
        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            pick = $urandom_range(0, 99);
            if (pick < 70) begin
                lam = RATE_W'($urandom_range(5, 16'h4000));
            end else if (pick < 85) begin
                lam = RATE_W'($urandom_range(0, 8));
            end else begin
                lam = RATE_W'($urandom_range(16'h4000, 16'hFFFF));
            end
            enr  = ($urandom_range(0, 4) == 0) ? PROB_W'($urandom) : exp_neg_of(lam);
            pick = $urandom_range(0, 9);
            if (pick < 6) begin
                tol = TOL_RESET;
            end else if (pick < 8) begin
                tol = TOL_W'($urandom);
            end else if (pick < 9) begin
                tol = '0;
            end else begin
                tol = '1;
            end
            // Upper data bits of the narrow registers carry noise.
            set_config({16'($urandom), lam}, enr, {16'($urandom), tol});
            sender_calm = ($urandom_range(0, 3) == 0);
            repeat (PHASE_ITEMS) begin
                pick = $urandom_range(0, 9);
                if (pick == 0) begin
                    u = 32'hFFFF_FFFF - PROB_W'($urandom_range(0, 16'hFFFF));
                end else if (pick == 1) begin
                    u = PROB_W'($urandom_range(0, 32'h0001_FFFF));
                end else begin
                    u = PROB_W'($urandom);
                end
                offer_uniform(u);
            end
            in_valid <= 1'b0;
        end

        // Drain, then give the block time to show any stray result.
        sender_calm = 1'b0;
        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Covered %0d requests over %0d register settings plus reset defaults,",
                 chk_requests, settings_done);
        $display("including %0d searches that ran into the count limit.", chk_saturations);
        if (chk_errors == 0 && chk_pending == 0) begin
            $display("** poisson_inversion_sampler_core: PASSED **");
        end else begin
            $display("%0d mismatches, %0d results never arrived", chk_errors, chk_pending);
            $display("** poisson_inversion_sampler_core: FAILED **");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
design/pis_pkg.sv
design/pis_serial_muldiv.sv
design/poisson_inversion_sampler_core.sv
verif/pis_sample_checker.sv
verif/poisson_inversion_sampler_core_tb.sv
